// ----- src/modinv_pkg.sv -----
// Shared types and constants for the modular inverse block.
// Holds the stream layout and the controller/datapath command and status structs.
// No dependencies.
package modinv_pkg;

    // Stream field width and padded tdata width on both channels
    localparam int FIELD_W = 63;
    localparam int TDATA_W = 128;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture operands, order them, reset coefficients
        logic div_init;  // start a division of big by small
        logic div_step;  // one restoring-division bit
        logic update;    // advance the Euclid round
        logic fix;       // add modulus to a negative coefficient
        logic emit;      // load the result register
    } modinv_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic small_zero;  // remainder sequence has ended
        logic div_last;    // current division step is the last one
    } modinv_stat_t;

endpackage

// ----- src/modinv_dpath.sv -----
// Datapath for the modular inverse: operand registers, bit-serial divider
// with a shift-add coefficient product, and the result register.
// Depends on modinv_pkg.
module modinv_dpath
    import modinv_pkg::*;
#(
    parameter int OPERAND_WIDTH = 63
) (
    input  logic               aclk,
    input  logic [TDATA_W-1:0] s_tdata,
    input  modinv_cmd_t        cmd,
    output modinv_stat_t       stat,
    output logic [TDATA_W-1:0] m_tdata
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CW    = W + 1;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     big_reg, big_next;
    logic [W-1:0]     small_reg, small_next;
    logic [W-1:0]     mod_reg, mod_next;
    logic [CW-1:0]    coef_prev_reg, coef_prev_next;
    logic [CW-1:0]    coef_cur_reg, coef_cur_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [CW-1:0]    prod_reg, prod_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     inv_reg, inv_next;
    logic [W-1:0]     gcd_reg, gcd_next;

    logic [W-1:0]     in_exp;
    logic [W-1:0]     in_mod;
    logic [W:0]       shifted;
    logic [W:0]       trial;
    logic             qbit;

    assign in_exp  = s_tdata[W-1:0];
    assign in_mod  = s_tdata[FIELD_W+W-1:FIELD_W];

    // Trial subtraction of one restoring-division step
    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign trial   = shifted - {1'b0, small_reg};
    assign qbit    = ~trial[W];

    assign stat.small_zero = (small_reg == '0);
    assign stat.div_last   = (cnt_reg == '0);

    // Next-state logic for all datapath registers
    always_comb begin
        big_next       = big_reg;
        small_next     = small_reg;
        mod_next       = mod_reg;
        coef_prev_next = coef_prev_reg;
        coef_cur_next  = coef_cur_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        inv_next       = inv_reg;
        gcd_next       = gcd_reg;

        if (cmd.load) begin
            big_next       = (in_exp > in_mod) ? in_exp : in_mod;
            small_next     = (in_exp < in_mod) ? in_exp : in_mod;
            mod_next       = in_mod;
            coef_prev_next = '0;
            coef_cur_next  = CW'(1);
        end

        if (cmd.div_init) begin
            rem_next  = '0;
            dvd_next  = big_reg;
            prod_next = '0;
            cnt_next  = CNT_W'(W - 1);
        end

        // One quotient bit; accumulate coef_cur * quotient MSB first
        if (cmd.div_step) begin
            rem_next  = qbit ? trial[W-1:0] : shifted[W-1:0];
            dvd_next  = {dvd_reg[W-2:0], 1'b0};
            prod_next = {prod_reg[CW-2:0], 1'b0} + (qbit ? coef_cur_reg : '0);
            cnt_next  = cnt_reg - CNT_W'(1);
        end

        if (cmd.update) begin
            big_next       = small_reg;
            small_next     = rem_reg;
            coef_prev_next = coef_cur_reg;
            coef_cur_next  = coef_prev_reg - prod_reg;
        end

        // Bring a negative coefficient up by the modulus
        if (cmd.fix && coef_prev_reg[CW-1]) begin
            coef_prev_next = coef_prev_reg + {1'b0, mod_reg};
        end

        if (cmd.emit) begin
            inv_next = coef_prev_reg[W-1:0];
            gcd_next = big_reg;
        end
    end

    always_ff @(posedge aclk) begin
        big_reg       <= big_next;
        small_reg     <= small_next;
        mod_reg       <= mod_next;
        coef_prev_reg <= coef_prev_next;
        coef_cur_reg  <= coef_cur_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        prod_reg      <= prod_next;
        cnt_reg       <= cnt_next;
        inv_reg       <= inv_next;
        gcd_reg       <= gcd_next;
    end

    // Pack the result: inverse low, gcd above, zero padding
    always_comb begin
        m_tdata = '0;
        m_tdata[W-1:0]                 = inv_reg;
        m_tdata[FIELD_W+W-1:FIELD_W]   = gcd_reg;
    end

endmodule

// ----- src/modinv_ctrl.sv -----
// Controller for the modular inverse: sequences load, Euclid rounds,
// sign fix and result transfer.
// Depends on modinv_pkg.
module modinv_ctrl
    import modinv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  modinv_stat_t stat,
    output modinv_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FIX,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = ~m_tvalid_reg | m_tready;

    // Decode commands and next state
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.small_zero) begin
                    state_next = ST_FIX;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the result register is free
                if (out_free) begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- src/modular_inverse_ext_euclid_top.sv -----
// Modular inverse by the extended Euclidean algorithm, 63-bit operands.
// Each input transfer starts R Euclid rounds (R up to 90 at full width), then a sign fix and the
// result transfer; each round is a check state, a bit-serial division of one bit a cycle and an
// update state.
// Throughput: one item at a time; the next input is taken once the result is registered.
// Reset: synchronous active-low aresetn returns the controller to idle and drops m_tvalid.
module modular_inverse_ext_euclid_top
    import modinv_pkg::*;
#(
    parameter int OPERAND_WIDTH = 63
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [62:0] exponent, [125:63] modulus, rest zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // [62:0] inverse, [125:63] common_divisor, rest zero
);

    modinv_cmd_t  cmd;
    modinv_stat_t stat;

    modinv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    modinv_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

    // A zero gcd only arises from two zero operands, which give a zero inverse
    a_zero_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2*FIELD_W-1:FIELD_W] == '0) |-> (m_tdata[FIELD_W-1:0] == '0))
        else $error("zero gcd with nonzero inverse");

    // An accepted item keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while busy");

    // Reset leaves the block idle with no pending result
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

endmodule
